// ===== hw/rtl/lssc_pkg.sv =====
// Shared types and constants for the spaced LSB stego codec.
`default_nettype none

package lssc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SpacingW = 8;
  localparam int unsigned HdrLenW  = 10;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [BitIdxW-1:0] LastBit = 3'd7;

  localparam logic [SpacingW-1:0] SpacingReset = 8'd1;
  localparam logic [HdrLenW-1:0]  HdrLenReset  = 10'd54;

  typedef enum logic {
    MODE_EMBED   = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_STREAM = 1'b0,
    KIND_CHAR   = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE    = 2'd0,
    CFG_SPACING = 2'd1,
    CFG_HDR_LEN = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] carrier_byte;
    logic [ByteW-1:0] secret_byte;
    logic             secret_present;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_kind;
    logic             secret_taken;
    logic             message_end;
  } out_item_t;

  typedef struct packed {
    mode_e                mode;
    logic [SpacingW-1:0]  spacing;
    logic [HdrLenW-1:0]   header_len;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lssc_in_reg.sv =====
// Input register: holds one accepted transaction until the core consumes it.
`default_nettype none

module lssc_in_reg
  import lssc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  output logic          in_stall_o,
  input  wire logic     consume_i,
  output logic          item_valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     accept;

  // Take a new transaction whenever the held one is empty or leaving.
  assign in_stall_o = valid_q && !consume_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lssc_core.sv =====
// Codec state and per-byte embed/extract logic.
`default_nettype none

module lssc_core
  import lssc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output out_item_t     res_o
);

  logic [HdrLenW-1:0]  header_count_q, header_count_d;
  logic [SpacingW-1:0] gap_count_q, gap_count_d;
  logic [BitIdxW-1:0]  bit_index_q, bit_index_d;
  logic [ByteW-1:0]    char_acc_q, char_acc_d;
  logic                finished_q, finished_d;

  logic             in_header;
  logic             carrier;
  logic             embed_bit;
  logic [ByteW-1:0] acc_new;

  assign in_header = header_count_q < cfg_i.header_len;
  assign carrier   = gap_count_q == '0;
  assign embed_bit = carrier && item_i.secret_present;
  assign acc_new   = char_acc_q | (ByteW'(item_i.carrier_byte[0]) << bit_index_q);

  always_comb begin
    header_count_d = header_count_q;
    gap_count_d    = gap_count_q;
    bit_index_d    = bit_index_q;
    char_acc_d     = char_acc_q;
    finished_d     = finished_q;
    res_valid_o    = 1'b0;
    res_o          = '{out_byte: item_i.carrier_byte, out_kind: KIND_STREAM,
                       secret_taken: 1'b0, message_end: 1'b0};

    if (cfg_i.mode == MODE_EXTRACT && finished_q) begin
      // Message over: drop the byte
    end else if (in_header) begin
      header_count_d = header_count_q + 1'b1;
      res_valid_o    = cfg_i.mode == MODE_EMBED;
    end else begin
      // Wrap also when spacing was lowered under the running count
      if (gap_count_q >= cfg_i.spacing) begin
        gap_count_d = '0;
      end else begin
        gap_count_d = gap_count_q + 1'b1;
      end

      if (cfg_i.mode == MODE_EMBED) begin
        res_valid_o       = 1'b1;
        res_o.out_byte[0] = embed_bit ? item_i.secret_byte[bit_index_q] : 1'b0;
        if (embed_bit) begin
          res_o.secret_taken = bit_index_q == LastBit;
          bit_index_d        = bit_index_q + 1'b1;
        end
      end else if (carrier) begin
        if (bit_index_q != LastBit) begin
          char_acc_d  = acc_new;
          bit_index_d = bit_index_q + 1'b1;
        end else begin
          res_valid_o       = 1'b1;
          res_o.out_byte    = acc_new;
          res_o.out_kind    = KIND_CHAR;
          res_o.message_end = acc_new == '0;
          finished_d        = acc_new == '0;
          bit_index_d       = '0;
          char_acc_d        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_count_q <= '0;
      gap_count_q    <= '0;
      bit_index_q    <= '0;
      char_acc_q     <= '0;
      finished_q     <= 1'b0;
    end else if (step_i) begin
      header_count_q <= header_count_d;
      gap_count_q    <= gap_count_d;
      bit_index_q    <= bit_index_d;
      char_acc_q     <= char_acc_d;
      finished_q     <= finished_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lssc_out_reg.sv =====
// Result register: holds one result transaction until the sink takes it.
`default_nettype none

module lssc_out_reg
  import lssc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  output out_item_t      out_data_o,
  input  wire logic      out_stall_i
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_spaced_stego_codec.sv =====
// Top level of the spaced LSB stego codec: configuration registers and datapath.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------
//   in      | sink      | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//   out     | source    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One byte per cycle sustained while the output does not stall. A byte passes
// through the input register, then the result register, with the single pass of
// counter and bit-select logic in the core between them. Header bytes in extract
// mode, and in extract mode every byte that does not complete a character, are
// consumed without a result. Reset clears all counters and loads the register
// defaults. A stall on the output holds the result register and, once the input
// register is full too, stalls the input.
`default_nettype none

module lsb_spaced_stego_codec
  import lssc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire in_item_t            in_data_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output out_item_t                out_data_o,
  input  wire logic                out_stall_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  logic      item_valid;
  in_item_t  item;
  logic      out_ready;
  logic      step;
  logic      res_valid;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_EMBED, spacing: SpacingReset, header_len: HdrLenReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:    cfg_q.mode       <= mode_e'(cfg_wdata_i[0]);
        CFG_SPACING: cfg_q.spacing    <= cfg_wdata_i[SpacingW-1:0];
        CFG_HDR_LEN: cfg_q.header_len <= cfg_wdata_i[HdrLenW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held byte only when the result register can take its result
  assign step = item_valid && out_ready;

  lssc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .consume_i    (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lssc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lssc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
